// ----- sv/lru_frame_replacer_top_defines.svh -----
// ----------------------------------------------------------------------------
// lru_frame_replacer_top_defines.svh
// Assertion macros shared by the replacer checker.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACER_TOP_DEFINES_SVH

// Checked while out of reset.
`define LRUFR_CHK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LRUFR_CHK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/lrufr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrufr_pkg
// Item types, command codes and internal control types of the replacer.
// ----------------------------------------------------------------------------
package lrufr_pkg;

    localparam int FID_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] CMD_VICTIM = 2'd0;
    localparam logic [1:0] CMD_PIN = 2'd1;
    localparam logic [1:0] CMD_UNPIN = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [FID_W-1:0] frame_num;
    } t_in_item;

    typedef struct packed {
        logic                 found;
        logic [FID_W-1:0]     victim_frame;
        logic [CNT_OUT_W-1:0] tracked_count;
    } t_out_item;

    // Requests from the sequencer to the recency ring
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic pop;
    } t_ring_op;

endpackage

// ----- sv/lrufr_ring.sv -----
// ----------------------------------------------------------------------------
// lrufr_ring
// Recency list held as a circular buffer in one synchronous RAM.
// Ports address by logical position (0 = least recent); pop advances head.
// ----------------------------------------------------------------------------
module lrufr_ring #(
    parameter int FRAMES = 64,
    localparam int IDX_W = $clog2(FRAMES),
    localparam int CNT_W = $clog2(FRAMES + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lrufr_pkg::t_ring_op      i_op,
    input  logic [CNT_W-1:0]         i_rd_pos,
    input  logic [CNT_W-1:0]         i_wr_pos,
    input  logic [lrufr_pkg::FID_W-1:0] i_wr_data,
    output logic [lrufr_pkg::FID_W-1:0] o_rd_data
);

    logic [lrufr_pkg::FID_W-1:0] r_mem [FRAMES];
    logic [lrufr_pkg::FID_W-1:0] r_rd_data;
    logic [IDX_W-1:0]            r_head;
    logic [IDX_W-1:0]            n_head;
    logic [CNT_W:0]              rd_sum;
    logic [CNT_W:0]              wr_sum;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            wr_addr;

    // head + pos stays below 2*FRAMES: one conditional subtract wraps it
    assign rd_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(i_rd_pos);
    assign wr_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(i_wr_pos);
    assign rd_addr = (32'(rd_sum) >= FRAMES) ? IDX_W'(32'(rd_sum) - FRAMES) : IDX_W'(rd_sum);
    assign wr_addr = (32'(wr_sum) >= FRAMES) ? IDX_W'(32'(wr_sum) - FRAMES) : IDX_W'(wr_sum);

    always_comb begin
        n_head = r_head;
        if (i_op.pop) begin
            n_head = (32'(r_head) == FRAMES - 1) ? '0 : r_head + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
        if (i_op.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/lru_frame_replacer_top.sv -----
// ----------------------------------------------------------------------------
// lru_frame_replacer_top
// Least-recently-unpinned frame replacement list with victim selection.
// ----------------------------------------------------------------------------
// Usage:
//   Command items (victim / pin / unpin plus a frame number) enter on the
//   i_valid / o_ready channel; each item yields exactly one result item on
//   o_valid / i_ready: found flag, victim frame and tracked count.
//   The capacity register is written on i_cfg_valid; o_cfg_ready is always
//   high. Write it only while no item is in flight.
// Sequencer states from accept to the result, one item in flight at a time:
//   victim on an empty list, unused code, frame past the table: DONE
//   victim: POP, DONE; pin or unpin that changes nothing: CHECK, DONE
//   unpin of a new frame: CHECK, APPEND, DONE; POP first if the oldest goes
//   pin of a tracked frame: CHECK, SCAN, DONE; in SCAN the
//   list is walked one RAM read per cycle, entries behind the hit move down.
// A new item is taken the cycle after the result is loaded; no new item is
// taken before the last one is done. The result waits in an output register,
// so the next item is taken while the receiver stalls; a second result then
// waits until the first leaves.
// Reset sets the capacity back to 64 and starts a clearing pass over the
// tracked flags, one per cycle: o_ready stays low until the pass is done.
// ----------------------------------------------------------------------------
module lru_frame_replacer_top #(
    parameter int FRAMES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lrufr_pkg::t_in_item         i_item,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output lrufr_pkg::t_out_item        o_item,
    // capacity register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrufr_pkg::CAP_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_POP    = 3'd1;  // head entry read, drop it
    localparam logic [2:0] ST_APPEND = 3'd2;  // write new frame at tail
    localparam logic [2:0] ST_SCAN   = 3'd3;  // pin: walk and compact
    localparam logic [2:0] ST_DONE   = 3'd4;  // result waits for out reg
    localparam logic [2:0] ST_CLEAR  = 3'd5;  // zero the flags after reset
    localparam logic [2:0] ST_CHECK  = 3'd6;  // tracked flag read back

    logic [2:0]                        r_state, n_state;
    logic [1:0]                        r_cmd, n_cmd;
    logic [lrufr_pkg::FID_W-1:0]       r_fid, n_fid;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic [CNT_W-1:0]                  r_rd_pos, n_rd_pos;
    logic                              r_hit, n_hit;
    logic [IDX_W-1:0]                  r_clr_idx, n_clr_idx;
    logic [lrufr_pkg::CAP_W-1:0]       r_cap;
    logic                              r_found, n_found;
    logic [lrufr_pkg::FID_W-1:0]       r_victim, n_victim;
    logic                              r_out_valid, n_out_valid;
    lrufr_pkg::t_out_item              r_out, n_out;

    // tracked flags, one synchronous RAM entry per frame
    logic                              r_flag_mem [FRAMES];
    logic                              r_flag_rd;
    logic                              flag_rd_en;
    logic                              flag_we;
    logic [IDX_W-1:0]                  flag_waddr;
    logic                              flag_wdata;

    lrufr_pkg::t_ring_op               ring_op;
    logic [CNT_W-1:0]                  rd_pos;
    logic [CNT_W-1:0]                  wr_pos;
    logic [lrufr_pkg::FID_W-1:0]       wr_data;
    logic [lrufr_pkg::FID_W-1:0]       rd_data;

    logic                              in_fire;
    logic                              fid_ok;
    logic [IDX_W-1:0]                  in_idx;
    logic [IDX_W-1:0]                  fid_idx;
    logic [IDX_W-1:0]                  rd_idx;
    logic [CNT_W-1:0]                  cap_eff;
    logic                              need_drop;
    logic                              scan_last;

    assign o_ready     = (r_state == ST_IDLE);
    assign in_fire     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // frame numbers past the table are ignored
    assign fid_ok  = (32'(i_item.frame_num) < FRAMES);
    assign in_idx  = IDX_W'(i_item.frame_num);
    assign fid_idx = IDX_W'(r_fid);
    assign rd_idx  = IDX_W'(rd_data);

    // capacity clamped to 1..FRAMES
    always_comb begin
        priority if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(r_cap) > FRAMES) begin
            cap_eff = CNT_W'(FRAMES);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    assign need_drop = (r_count != '0) && (r_count >= cap_eff);
    assign scan_last = ((r_rd_pos + CNT_W'(1)) == r_count);

    // RAM addressing: reads walk forward in SCAN, else hit the head
    assign rd_pos  = (r_state == ST_SCAN) ? r_rd_pos + CNT_W'(1) : '0;
    assign wr_pos  = (r_state == ST_APPEND) ? r_count : r_rd_pos - CNT_W'(1);
    assign wr_data = (r_state == ST_APPEND) ? r_fid : rd_data;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fid       = r_fid;
        n_count     = r_count;
        n_rd_pos    = r_rd_pos;
        n_hit       = r_hit;
        n_clr_idx   = r_clr_idx;
        n_found     = r_found;
        n_victim    = r_victim;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ring_op     = '0;
        flag_rd_en  = 1'b0;
        flag_we     = 1'b0;
        flag_waddr  = fid_idx;
        flag_wdata  = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = r_clr_idx;
                if (32'(r_clr_idx) == FRAMES - 1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + IDX_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_cmd    = i_item.command;
                    n_fid    = i_item.frame_num;
                    n_found  = 1'b0;
                    n_victim = '0;
                    n_rd_pos = '0;
                    n_hit    = 1'b0;
                    n_state  = ST_DONE;
                    priority if (i_item.command == lrufr_pkg::CMD_VICTIM) begin
                        if (r_count != '0) begin
                            ring_op.rd_en = 1'b1;
                            n_state       = ST_POP;
                        end
                    end else if (i_item.command == lrufr_pkg::CMD_PIN) begin
                        if (fid_ok) begin
                            flag_rd_en = 1'b1;
                            n_state    = ST_CHECK;
                        end
                    end else if (i_item.command == lrufr_pkg::CMD_UNPIN) begin
                        if (fid_ok) begin
                            flag_rd_en = 1'b1;
                            n_state    = ST_CHECK;
                        end
                    end else begin
                        n_state = ST_DONE;  // unused code: no operation
                    end
                end
            end
            ST_CHECK: begin
                // flag writes land before the next item's read: no forwarding
                n_state = ST_DONE;
                if (r_cmd == lrufr_pkg::CMD_PIN) begin
                    if (r_flag_rd) begin
                        ring_op.rd_en = 1'b1;
                        n_state       = ST_SCAN;
                    end
                end else if (!r_flag_rd) begin
                    if (need_drop) begin
                        ring_op.rd_en = 1'b1;
                        n_state       = ST_POP;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_POP: begin
                ring_op.pop = 1'b1;
                flag_we     = 1'b1;
                flag_waddr  = rd_idx;
                n_count     = r_count - CNT_W'(1);
                if (r_cmd == lrufr_pkg::CMD_VICTIM) begin
                    n_found  = 1'b1;
                    n_victim = rd_data;
                    n_state  = ST_DONE;
                end else begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                ring_op.wr_en = 1'b1;
                flag_we       = 1'b1;
                flag_wdata    = 1'b1;
                n_count       = r_count + CNT_W'(1);
                n_state       = ST_DONE;
            end
            ST_SCAN: begin
                // rd_data holds the entry at r_rd_pos; past the hit, shift down
                ring_op.rd_en = !scan_last;
                ring_op.wr_en = r_hit;
                if (rd_data == r_fid) begin
                    n_hit = 1'b1;
                end
                if (scan_last) begin
                    flag_we = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_DONE;
                end else begin
                    n_rd_pos = r_rd_pos + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.found         = r_found;
                    n_out.victim_frame  = r_victim;
                    n_out.tracked_count = lrufr_pkg::CNT_OUT_W'(r_count);
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_cap       <= lrufr_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // tracked flag RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[flag_waddr] <= flag_wdata;
        end
        if (flag_rd_en) begin
            r_flag_rd <= r_flag_mem[in_idx];
        end
    end

    // payload and scan working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_fid    <= n_fid;
        r_rd_pos <= n_rd_pos;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_victim <= n_victim;
        r_out    <= n_out;
    end

    lrufr_ring #(
        .FRAMES (FRAMES)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (ring_op),
        .i_rd_pos  (rd_pos),
        .i_wr_pos  (wr_pos),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ----- sv/lrufr_checker.sv -----
// ----------------------------------------------------------------------------
// lrufr_checker
// Port-level checks on the replacer result channel.
// ----------------------------------------------------------------------------
`include "lru_frame_replacer_top_defines.svh"

module lrufr_checker #(
    parameter int FRAMES = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input lrufr_pkg::t_out_item o_item
);

    `LRUFR_CHK(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_item), "result changed while stalled")

    `LRUFR_CHK(a_no_victim_zero, o_valid && !o_item.found |-> o_item.victim_frame == '0, "victim frame nonzero without found")

    `LRUFR_CHK(a_count_bound, o_valid |-> (32'(o_item.tracked_count) <= FRAMES) && (o_item.tracked_count <= 7'd64), "tracked count beyond table")

    `LRUFR_CHK_RST(a_reset_idle, !i_rst_n |=> !o_valid, "result valid right after reset")

endmodule

bind lru_frame_replacer_top lrufr_checker #(
    .FRAMES (FRAMES)
) u_lrufr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

// ----- tb/tb_lru_frame_replacer_top.sv -----
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_top
// Self-checking bench for the LRU frame replacement list.
// ----------------------------------------------------------------------------
// A short table of hand-picked commands comes first: the empty list, ignored
// pins and unpins, the unused code, capacity zero and the top capacity, and a
// capacity lowered under the tracked count. Random traffic follows in eight
// phases. Each phase sets its own capacity, command mix and idling pattern.
// A local copy of the recency list predicts the results that the table does
// not type in, and the results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_lru_frame_replacer_top;

    localparam int N_FRAMES = 64;
    // Command code with no function; the block must answer it with a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 80;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    lrufr_pkg::t_in_item         i_item = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    lrufr_pkg::t_out_item        o_item;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [lrufr_pkg::CAP_W-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    lru_frame_replacer_top #(
        .FRAMES(N_FRAMES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the replacer: the recency list (front is least
    // recent), the membership flags and the capacity register.
    // ------------------------------------------------------------------
    logic [lrufr_pkg::FID_W-1:0] lru_order [$];
    bit                          in_list [N_FRAMES];
    logic [lrufr_pkg::CAP_W-1:0] cap_reg = lrufr_pkg::CAP_RESET;

    // Result items still owed by the block, oldest first.
    lrufr_pkg::t_out_item pending_results [$];

    // Idling knobs. send_idle_pct is owned by the stimulus process;
    // stall_pct is read by the receiver, so it is only changed with NBAs.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Bookkeeping for the run summary and the verdict.
    int n_sent = 0;
    int n_results = 0;
    int n_victims = 0;
    int n_pin_hits = 0;
    int n_drops = 0;
    int peak_count = 0;
    int err_count = 0;

    // Per-phase capacity and share of unpin commands (percent). The 92%
    // phases fill the list to all 64 frames so that unpins start dropping.
    int phase_cap [8] = '{64, 1, 5, 127, 0, 16, 65, 3};
    int phase_unpin [8] = '{92, 45, 70, 45, 70, 45, 92, 45};

    // Directed stimulus table: either a capacity write or one command item,
    // optionally with a hand-typed expected result.
    typedef struct {
        bit                          wr_cap;
        logic [lrufr_pkg::CAP_W-1:0] cap;
        lrufr_pkg::t_in_item         it;
        bit                          typed;
        lrufr_pkg::t_out_item        want;
    } t_stim_row;

    t_stim_row stim_rows [$];

    function automatic void add_row(bit wr_cap, int cap, logic [1:0] cmd, int fid,
                                    bit typed, int fnd, int vic, int cnt);
        t_stim_row sr;
        sr.wr_cap = wr_cap;
        sr.cap = lrufr_pkg::CAP_W'(cap);
        sr.it.command = cmd;
        sr.it.frame_num = lrufr_pkg::FID_W'(fid);
        sr.typed = typed;
        sr.want.found = fnd[0];
        sr.want.victim_frame = lrufr_pkg::FID_W'(vic);
        sr.want.tracked_count = lrufr_pkg::CNT_OUT_W'(cnt);
        stim_rows.push_back(sr);
    endfunction

    // Remove and return the least recent frame of the shadow list.
    function automatic logic [lrufr_pkg::FID_W-1:0] pop_oldest();
        logic [lrufr_pkg::FID_W-1:0] f;
        f = lru_order.pop_front();
        in_list[f] = 1'b0;
        return f;
    endfunction

    // Apply one command to the shadow list and return the result it yields.
    function automatic lrufr_pkg::t_out_item apply_lru_cmd(lrufr_pkg::t_in_item it);
        lrufr_pkg::t_out_item r;
        int eff_cap;
        int j;
        r = '0;
        // capacity 0 acts as 1, anything past the frame count as the count
        eff_cap = int'(cap_reg);
        if (eff_cap == 0) eff_cap = 1;
        if (eff_cap > N_FRAMES) eff_cap = N_FRAMES;
        case (it.command)
            lrufr_pkg::CMD_VICTIM: begin
                if (lru_order.size() > 0) begin
                    r.found = 1'b1;
                    r.victim_frame = pop_oldest();
                    n_victims++;
                end
            end
            lrufr_pkg::CMD_PIN: begin
                if (in_list[it.frame_num]) begin
                    for (j = 0; j < lru_order.size(); j++) begin
                        if (lru_order[j] == it.frame_num) begin
                            lru_order.delete(j);
                            break;
                        end
                    end
                    in_list[it.frame_num] = 1'b0;
                    n_pin_hits++;
                end
            end
            lrufr_pkg::CMD_UNPIN: begin
                // a frame already tracked keeps its place
                if (!in_list[it.frame_num]) begin
                    // full: the oldest entry goes, only one even when the
                    // capacity was lowered under the current count
                    if (lru_order.size() >= eff_cap && lru_order.size() > 0) begin
                        void'(pop_oldest());
                        n_drops++;
                    end
                    if (lru_order.size() < N_FRAMES) begin
                        lru_order.push_back(it.frame_num);
                        in_list[it.frame_num] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.tracked_count = lrufr_pkg::CNT_OUT_W'(lru_order.size());
        if (lru_order.size() > peak_count) peak_count = lru_order.size();
        return r;
    endfunction

    // Random command. Frame numbers are steered toward tracked frames for
    // pins, and mostly toward untracked frames for unpins, so the list
    // actually grows and pins hit entries at every depth.
    function automatic lrufr_pkg::t_in_item next_random_item(int unpin_pct);
        lrufr_pkg::t_in_item it;
        int r;
        int k;
        int start;
        int j;
        it.frame_num = lrufr_pkg::FID_W'($urandom_range(N_FRAMES - 1));
        r = $urandom_range(99);
        if (r < 4) begin
            it.command = CMD_UNUSED;
        end else if (r < 4 + unpin_pct) begin
            it.command = lrufr_pkg::CMD_UNPIN;
            k = $urandom_range(9);
            if (k < 2 && lru_order.size() > 0) begin
                it.frame_num = lru_order[$urandom_range(lru_order.size() - 1)];
            end else if (k < 7) begin
                start = $urandom_range(N_FRAMES - 1);
                for (j = 0; j < N_FRAMES; j++) begin
                    if (!in_list[(start + j) % N_FRAMES]) begin
                        it.frame_num = lrufr_pkg::FID_W'((start + j) % N_FRAMES);
                        break;
                    end
                end
            end
        end else if (r < 4 + unpin_pct + (96 - unpin_pct) / 2) begin
            it.command = lrufr_pkg::CMD_PIN;
            if ($urandom_range(2) != 0 && lru_order.size() > 0)
                it.frame_num = lru_order[$urandom_range(lru_order.size() - 1)];
        end else begin
            it.command = lrufr_pkg::CMD_VICTIM;
        end
        return it;
    endfunction

    function automatic void note_fail(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // Command driver. Optional idle cycles first, then valid stays up with
    // a steady payload until the block takes the item. The shadow list is
    // updated at the accepting edge, so the prediction sees every earlier
    // item in order. Valid is left high: the next call either keeps it up
    // or drops it for an idle gap.
    // ------------------------------------------------------------------
    task automatic send_cmd(input lrufr_pkg::t_in_item it, input bit typed,
                            input lrufr_pkg::t_out_item want);
        lrufr_pkg::t_out_item pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_lru_cmd(it);
        pending_results.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Stop sending and wait until every owed result has come back, then
    // let the block settle before going on.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Capacity write, only ever issued with the block idle.
    task automatic write_capacity(input logic [lrufr_pkg::CAP_W-1:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = v;
    endtask

    // ------------------------------------------------------------------
    // Receiver: i_ready is redrawn every cycle from the current stall rate.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        lrufr_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_fail($sformatf("unexpected result found=%0d victim=%0d count=%0d",
                                    o_item.found, o_item.victim_frame,
                                    o_item.tracked_count));
            end else begin
                want = pending_results.pop_front();
                if (o_item.found !== want.found)
                    note_fail($sformatf("found: expected %0d, got %0d",
                                        want.found, o_item.found));
                if (o_item.victim_frame !== want.victim_frame)
                    note_fail($sformatf("victim_frame: expected %0d, got %0d",
                                        want.victim_frame, o_item.victim_frame));
                if (o_item.tracked_count !== want.tracked_count)
                    note_fail($sformatf("tracked_count: expected %0d, got %0d",
                                        want.tracked_count, o_item.tracked_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;
        int k;
        t_stim_row sr;
        lrufr_pkg::t_in_item it;

        //  cap value command                 frame typed fnd vic cnt
        // empty list: victim, pin of an untracked frame, unused code
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 0,  1, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_PIN,    5,  1, 0, 0, 0);
        add_row(0, 0,   CMD_UNUSED,            63, 1, 0, 0, 0);
        // lowest and highest frame, then an unpin of a tracked frame
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  0,  1, 0, 0, 1);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  63, 1, 0, 0, 2);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  0,  1, 0, 0, 2);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  42, 0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_PIN,    63, 0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 63, 0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 0,  1, 0, 0, 0);
        // capacity zero behaves as one: the second unpin evicts the first
        add_row(1, 0,   lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  7,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  9,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        // top capacity, then lowered under the count: one drop per unpin
        add_row(1, 127, lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  1,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  2,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  3,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  4,  0, 0, 0, 0);
        add_row(1, 2,   lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_UNPIN,  5,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_PIN,    3,  0, 0, 0, 0);
        add_row(0, 0,   lrufr_pkg::CMD_VICTIM, 0,  0, 0, 0, 0);
        add_row(0, 0,   CMD_UNUSED,            0,  0, 0, 0, 0);

        // synchronous reset held low, then released
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            sr = stim_rows[i];
            if (sr.wr_cap) write_capacity(sr.cap);
            else send_cmd(sr.it, sr.typed, sr.want);
        end

        // Random phases. Idling cycles through: none, sender idle 53%,
        // receiver stall 53%, both 30%.
        for (p = 0; p < 8; p++) begin
            write_capacity(lrufr_pkg::CAP_W'(phase_cap[p]));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 53; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 53; end
                default: begin send_idle_pct = 30; stall_pct <= 30; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // one mid-phase pause with everything drained
                if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
                it = next_random_item(phase_unpin[p]);
                send_cmd(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Run: %0d commands, %0d results, %0d victims returned, %0d pin hits,",
                 n_sent, n_results, n_victims, n_pin_hits);
        $display("     %0d oldest-entry drops, peak list size %0d, capacities 0..127.",
                 n_drops, peak_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("** lru_frame_replacer_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count,
                     pending_results.size());
            $display("** lru_frame_replacer_top: FAILED **");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run (every pin walking the
    // whole list, every result stalled at the receiver).
    initial begin : watchdog
        #4000000;
        $display("Timeout: %0d results still owed", pending_results.size());
        $display("** lru_frame_replacer_top: FAILED **");
        $finish;
    end

endmodule
